// ===== rtl/sdgr_pkg.sv =====
// Shared types, screen geometry and the 3x5 digit font of the glyph renderer.
package sdgr_pkg;

   // Screen geometry.
   localparam int SCREEN_W = 240;
   localparam int SCREEN_H = 160;

   // Column and row widths just wide enough for on-screen coordinates.
   localparam int X_W = $clog2(SCREEN_W);
   localparam int Y_W = $clog2(SCREEN_H);

   // Width of the full row * width + column product before it is cut to 16 bits.
   localparam int ADDR_FULL_W = $clog2(SCREEN_W * SCREEN_H);

   // Screen bounds at the width of the signed pixel coordinates (11 bits).
   localparam logic [10:0] SCREEN_W_C = 11'(SCREEN_W);
   localparam logic [10:0] SCREEN_H_C = 11'(SCREEN_H);
   localparam logic [ADDR_FULL_W-1:0] SCREEN_W_A = ADDR_FULL_W'(SCREEN_W);

   // Glyph walk: five rows, three columns, four sub-pixels per cell.
   localparam logic [2:0] LAST_ROW = 3'd4;
   localparam logic [1:0] LAST_COL = 2'd2;
   localparam logic [1:0] LAST_SUB = 2'd3;

   // One glyph: five rows of three cells, row 0 first, column 0 in the MSB.
   typedef logic [0:4][2:0] glyph_type;

   // Digit font; codes above nine map to an empty glyph.
   localparam glyph_type GLYPH_FONT [16] = '{
      '{3'b111, 3'b101, 3'b101, 3'b101, 3'b111},
      '{3'b010, 3'b110, 3'b010, 3'b010, 3'b111},
      '{3'b111, 3'b001, 3'b111, 3'b100, 3'b111},
      '{3'b111, 3'b001, 3'b111, 3'b001, 3'b111},
      '{3'b101, 3'b101, 3'b111, 3'b001, 3'b001},
      '{3'b111, 3'b100, 3'b111, 3'b001, 3'b111},
      '{3'b111, 3'b100, 3'b111, 3'b101, 3'b111},
      '{3'b111, 3'b001, 3'b010, 3'b010, 3'b010},
      '{3'b111, 3'b101, 3'b111, 3'b101, 3'b111},
      '{3'b111, 3'b101, 3'b111, 3'b001, 3'b111},
      '{3'b000, 3'b000, 3'b000, 3'b000, 3'b000},
      '{3'b000, 3'b000, 3'b000, 3'b000, 3'b000},
      '{3'b000, 3'b000, 3'b000, 3'b000, 3'b000},
      '{3'b000, 3'b000, 3'b000, 3'b000, 3'b000},
      '{3'b000, 3'b000, 3'b000, 3'b000, 3'b000},
      '{3'b000, 3'b000, 3'b000, 3'b000, 3'b000}
   };

endpackage

// ===== rtl/sdgr_glyph_rom.sv =====
// Glyph font ROM with a registered read port.
module sdgr_glyph_rom (
   input  logic                clock,
   input  logic [3:0]          rd_digit,
   output sdgr_pkg::glyph_type rd_glyph
);
   import sdgr_pkg::*;

   glyph_type rd_glyph_ff;

   // Synchronous read of the whole glyph of the addressed digit.
   always_ff @(posedge clock) begin
      rd_glyph_ff <= GLYPH_FONT[rd_digit];
   end

   assign rd_glyph = rd_glyph_ff;

endmodule

// ===== rtl/scaled_digit_glyph_renderer.sv =====
// Top level of the scaled digit glyph renderer: slot walk, clipping, address and output.
//
// An item (origin, digit, color) is taken when start is high and busy is low. The block
// then walks all 60 sub-pixel slots of the 3x5 glyph (15 cells, each drawn as 2x2), one
// slot per cycle, whatever the digit or clipping; busy drops in the cycle of the final
// slot, so a following item starts with no gap. Each slot that is set and on screen
// becomes one framebuffer write on the rsp_ ports, marked by rsp_strobe for one cycle;
// writes of an item appear in row-major order, and the final one carries rsp_last_write.
// Digit codes above nine and fully clipped glyphs produce no writes. The receiver cannot
// stall: it must take every write in the cycle its strobe is high.
module scaled_digit_glyph_renderer (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [9:0]  req_origin_x,
   input  logic [9:0]  req_origin_y,
   input  logic [3:0]  req_digit_code,
   input  logic [15:0] req_ink_color,
   output logic        rsp_strobe,
   output logic [15:0] rsp_pixel_address,
   output logic [15:0] rsp_pixel_value,
   output logic        rsp_last_write
);
   import sdgr_pkg::*;

   // Slot walk and item registers.
   logic        active_ff;
   logic [2:0]  row_ff;
   logic [1:0]  col_ff;
   logic [1:0]  sub_ff;
   logic [9:0]  ox_ff;
   logic [9:0]  oy_ff;
   logic [3:0]  digit_ff;
   logic [15:0] color_ff;
   logic        final_slot;
   logic        accept;

   // Stage 1: glyph read back, coordinates computed.
   glyph_type   glyph;
   logic        s1_active_ff;
   logic        s1_end_ff;
   logic [2:0]  s1_row_ff;
   logic [1:0]  s1_col_ff;
   logic [1:0]  s1_sub_ff;
   logic [9:0]  s1_ox_ff;
   logic [9:0]  s1_oy_ff;
   logic [15:0] s1_color_ff;
   logic [10:0] px_s;
   logic [10:0] py_s;
   logic        cell_set;
   logic        on_screen;

   // Stage 2: clipped pixel, address computed.
   logic           s2_active_ff;
   logic           s2_valid_ff;
   logic           s2_end_ff;
   logic [X_W-1:0] s2_px_ff;
   logic [Y_W-1:0] s2_py_ff;
   logic [15:0]    s2_color_ff;
   logic [ADDR_FULL_W-1:0] addr_full;

   // Hold register: keeps one write back until it is known whether it is the last.
   logic        h_valid_ff;
   logic        h_close_ff;
   logic [15:0] h_addr_ff;
   logic [15:0] h_color_ff;
   logic        end_empty;
   logic        emit;
   logic        emit_last;

   // Output registers.
   logic        rsp_strobe_ff;
   logic [15:0] rsp_addr_ff;
   logic [15:0] rsp_value_ff;
   logic        rsp_last_ff;

   // Handshake: the walk is free in its final slot.
   assign final_slot = (row_ff == LAST_ROW) && (col_ff == LAST_COL) && (sub_ff == LAST_SUB);
   assign busy       = active_ff && !final_slot;
   assign accept     = start && !busy;

   // Slot walk: sub-pixel fastest, then column, then row.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         row_ff    <= '0;
         col_ff    <= '0;
         sub_ff    <= '0;
      end else if (accept) begin
         active_ff <= 1'b1;
         row_ff    <= '0;
         col_ff    <= '0;
         sub_ff    <= '0;
      end else if (active_ff) begin
         if (final_slot) begin
            active_ff <= 1'b0;
         end
         sub_ff <= sub_ff + 2'd1;
         if (sub_ff == LAST_SUB) begin
            if (col_ff == LAST_COL) begin
               col_ff <= '0;
               row_ff <= row_ff + 3'd1;
            end else begin
               col_ff <= col_ff + 2'd1;
            end
         end
      end
   end

   // Item payload is captured at acceptance.
   always_ff @(posedge clock) begin
      if (accept) begin
         ox_ff    <= req_origin_x;
         oy_ff    <= req_origin_y;
         digit_ff <= req_digit_code;
         color_ff <= req_ink_color;
      end
   end

   // Font ROM read, addressed by the digit of the item in the walk.
   sdgr_glyph_rom u_glyph_rom (
      .clock    (clock),
      .rd_digit (digit_ff),
      .rd_glyph (glyph)
   );

   // Slot data is registered alongside the ROM read, so it lines up with the glyph.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_active_ff <= 1'b0;
      end else begin
         s1_active_ff <= active_ff;
      end
      s1_end_ff   <= final_slot;
      s1_row_ff   <= row_ff;
      s1_col_ff   <= col_ff;
      s1_sub_ff   <= sub_ff;
      s1_ox_ff    <= ox_ff;
      s1_oy_ff    <= oy_ff;
      s1_color_ff <= color_ff;
   end

   // Pixel coordinates: origin plus 2*cell plus sub-pixel offset, and the screen clip.
   assign px_s      = {s1_ox_ff[9], s1_ox_ff} + {8'd0, s1_col_ff, s1_sub_ff[0]};
   assign py_s      = {s1_oy_ff[9], s1_oy_ff} + {7'd0, s1_row_ff, s1_sub_ff[1]};
   assign cell_set  = glyph[s1_row_ff][2'd2 - s1_col_ff];
   assign on_screen = !px_s[10] && (px_s < SCREEN_W_C) && !py_s[10] && (py_s < SCREEN_H_C);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_active_ff <= 1'b0;
         s2_valid_ff  <= 1'b0;
      end else begin
         s2_active_ff <= s1_active_ff;
         s2_valid_ff  <= s1_active_ff && cell_set && on_screen;
      end
      s2_end_ff   <= s1_end_ff;
      s2_px_ff    <= px_s[X_W-1:0];
      s2_py_ff    <= py_s[Y_W-1:0];
      s2_color_ff <= s1_color_ff;
   end

   // Framebuffer index: row times screen width plus column.
   assign addr_full = ADDR_FULL_W'(s2_py_ff) * SCREEN_W_A + ADDR_FULL_W'(s2_px_ff);

   // A held write goes out when a newer write arrives, when it closes its item,
   // or when its item ends without a further write.
   assign end_empty = s2_active_ff && s2_end_ff && !s2_valid_ff;
   assign emit      = h_valid_ff && (s2_valid_ff || h_close_ff || end_empty);
   assign emit_last = h_close_ff || end_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
         h_close_ff <= 1'b0;
      end else if (s2_valid_ff) begin
         h_valid_ff <= 1'b1;
         h_close_ff <= s2_end_ff;
      end else if (emit) begin
         h_valid_ff <= 1'b0;
         h_close_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         h_addr_ff  <= 16'(addr_full);
         h_color_ff <= s2_color_ff;
      end
   end

   // Output register: one write per cycle at most.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= emit;
      end
      rsp_addr_ff  <= h_addr_ff;
      rsp_value_ff <= h_color_ff;
      rsp_last_ff  <= emit && emit_last;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_pixel_address = rsp_addr_ff;
   assign rsp_pixel_value   = rsp_value_ff;
   assign rsp_last_write    = rsp_last_ff;

   // A write that closes its item leaves in the next cycle as the last one.
   a_close_emits_last: assert property (@(posedge clock) disable iff (reset)
      h_close_ff |=> rsp_strobe && rsp_last_write)
      else $error("closing write not emitted as last");

   // An accepted item restarts the walk at the first slot.
   a_accept_restarts: assert property (@(posedge clock) disable iff (reset)
      accept |=> active_ff && (row_ff == 3'd0) && (col_ff == 2'd0) && (sub_ff == 2'd0))
      else $error("walk not restarted on accept");

   // Only on-screen pixels reach the address stage as valid writes.
   a_clipped: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (ADDR_FULL_W'(s2_px_ff) < SCREEN_W_A)
                   && (32'(s2_py_ff) < 32'(SCREEN_H)))
      else $error("off-screen pixel passed the clip");

   // A valid pixel in stage 2 always comes from an active slot.
   a_valid_active: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> s2_active_ff)
      else $error("valid pixel without an active slot");

endmodule

// ===== tb/glyph_write_checker.sv =====
// Checker that predicts the framebuffer writes of each glyph item and compares them.
module glyph_write_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [9:0]  req_origin_x,
   input  logic [9:0]  req_origin_y,
   input  logic [3:0]  req_digit_code,
   input  logic [15:0] req_ink_color,
   input  logic        rsp_strobe,
   input  logic [15:0] rsp_pixel_address,
   input  logic [15:0] rsp_pixel_value,
   input  logic        rsp_last_write,
   output int          outstanding,
   output int          failures
);
   timeunit 1ns;
   timeprecision 1ps;
   import sdgr_pkg::*;

   typedef struct packed {
      logic [15:0] address;
      logic [15:0] value;
      logic        last;
   } pixel_write_type;

   // Writes predicted for accepted items, oldest first.
   pixel_write_type expected_writes[$];

   initial begin
      outstanding = 0;
      failures = 0;
   end

   // Font of the ten digits, row 0 in the top three bits, column 0 leftmost in each row.
   function automatic logic [14:0] digit_pattern(input logic [3:0] digit);
      case (digit)
         4'd0: return 15'b111_101_101_101_111;
         4'd1: return 15'b010_110_010_010_111;
         4'd2: return 15'b111_001_111_100_111;
         4'd3: return 15'b111_001_111_001_111;
         4'd4: return 15'b101_101_111_001_001;
         4'd5: return 15'b111_100_111_001_111;
         4'd6: return 15'b111_100_111_101_111;
         4'd7: return 15'b111_001_010_010_010;
         4'd8: return 15'b111_101_111_101_111;
         4'd9: return 15'b111_101_111_001_111;
         default: return 15'b0;
      endcase
   endfunction

   // Queue the on-screen writes of one glyph in row-major order; the final one is marked last.
   function automatic void render_glyph(input logic [9:0] ox_bits, input logic [9:0] oy_bits,
                                        input logic [3:0] digit, input logic [15:0] color);
      logic [14:0]     pattern;
      int              ox, oy, px, py, r, c, dy, dx;
      pixel_write_type held;
      bit              have_held;
      pattern = digit_pattern(digit);
      ox = $signed(ox_bits);
      oy = $signed(oy_bits);
      have_held = 1'b0;
      held = '0;
      for (r = 0; r < 5; r++) begin
         for (c = 0; c < 3; c++) begin
            if (pattern[14 - (r * 3 + c)]) begin
               for (dy = 0; dy < 2; dy++) begin
                  for (dx = 0; dx < 2; dx++) begin
                     px = ox + 2 * c + dx;
                     py = oy + 2 * r + dy;
                     // Clipped writes are dropped entirely.
                     if (px >= 0 && px < SCREEN_W && py >= 0 && py < SCREEN_H) begin
                        if (have_held) begin
                           expected_writes.push_back(held);
                        end
                        held.address = 16'(py * SCREEN_W + px);
                        held.value = color;
                        held.last = 1'b0;
                        have_held = 1'b1;
                     end
                  end
               end
            end
         end
      end
      if (have_held) begin
         held.last = 1'b1;
         expected_writes.push_back(held);
      end
   endfunction

   // Compare each write with the oldest prediction, then predict any newly accepted item.
   always @(posedge clock) begin
      pixel_write_type want;
      if (reset) begin
         expected_writes.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_writes.size() == 0) begin
               $display("%0t: unexpected write, expected none, got address %0d value %h last %b",
                        $time, rsp_pixel_address, rsp_pixel_value, rsp_last_write);
               failures++;
            end else begin
               want = expected_writes.pop_front();
               if (rsp_pixel_address !== want.address) begin
                  $display("%0t: pixel_address expected %0d, got %0d",
                           $time, want.address, rsp_pixel_address);
                  failures++;
               end
               if (rsp_pixel_value !== want.value) begin
                  $display("%0t: pixel_value expected %h, got %h",
                           $time, want.value, rsp_pixel_value);
                  failures++;
               end
               if (rsp_last_write !== want.last) begin
                  $display("%0t: last_write expected %b, got %b",
                           $time, want.last, rsp_last_write);
                  failures++;
               end
            end
         end
         if (start && !busy) begin
            render_glyph(req_origin_x, req_origin_y, req_digit_code, req_ink_color);
         end
      end
      outstanding <= expected_writes.size();
   end

endmodule

// ===== tb/tb.sv =====
// Testbench top of the glyph renderer: clock, reset, glyph stimulus, watchdog and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sdgr_pkg::*;

   localparam int RESET_CYCLES   = 10;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 80;
   localparam int RANDOM_GLYPHS  = 150;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [9:0]  req_origin_x = '0;
   logic [9:0]  req_origin_y = '0;
   logic [3:0]  req_digit_code = '0;
   logic [15:0] req_ink_color = '0;
   logic        rsp_strobe;
   logic [15:0] rsp_pixel_address;
   logic [15:0] rsp_pixel_value;
   logic        rsp_last_write;

   int outstanding;
   int failures;
   int idle_pct = 27;

   scaled_digit_glyph_renderer dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_origin_x      (req_origin_x),
      .req_origin_y      (req_origin_y),
      .req_digit_code    (req_digit_code),
      .req_ink_color     (req_ink_color),
      .rsp_strobe        (rsp_strobe),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_last_write    (rsp_last_write)
   );

   glyph_write_checker write_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_origin_x      (req_origin_x),
      .req_origin_y      (req_origin_y),
      .req_digit_code    (req_digit_code),
      .req_ink_color     (req_ink_color),
      .rsp_strobe        (rsp_strobe),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_last_write    (rsp_last_write),
      .outstanding       (outstanding),
      .failures          (failures)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Offer one glyph item after a random idle gap and hold it until the block takes it.
   task automatic send_glyph(input int ox, input int oy, input logic [3:0] digit,
                             input logic [15:0] color);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_origin_x <= 10'(ox);
      req_origin_y <= 10'(oy);
      req_digit_code <= digit;
      req_ink_color <= color;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Hold off new items until every predicted write has come out.
   task automatic drain_writes();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Watchdog: end the run when nothing moves for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_strobe) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("Verification failed");
      $finish;
   end

   // Stimulus and verdict.
   initial begin
      int         ox, oy, drawn, phase, digit_i;
      logic [3:0] digit;
      drawn = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Every code, including the ones above nine, fully on screen.
      for (digit_i = 0; digit_i < 16; digit_i++) begin
         send_glyph(8, 8, 4'(digit_i), (digit_i % 2 == 0) ? 16'hFFFF : 16'h0000);
      end
      // Corners and edges: fully clipped, partly clipped on each side, flush with the edges.
      send_glyph(-512, -512, 4'd8, 16'h1234);
      send_glyph(511, 511, 4'd8, 16'h4321);
      send_glyph(-1, -1, 4'd8, 16'hA5A5);
      send_glyph(-5, -9, 4'd0, 16'h5A5A);
      send_glyph(SCREEN_W - 6, SCREEN_H - 10, 4'd8, 16'h7FFF);
      send_glyph(SCREEN_W - 5, SCREEN_H - 9, 4'd7, 16'h8000);
      send_glyph(SCREEN_W - 1, SCREEN_H - 1, 4'd0, 16'hFFFF);
      send_glyph(0, 0, 4'd7, 16'h0001);
      drain_writes();

      // Random glyphs in three phases of sender idling.
      for (phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 27 : (phase == 1) ? 79 : 0;
         while (drawn < (phase + 1) * RANDOM_GLYPHS / 3) begin
            if ($urandom_range(99) < 75) begin
               // Mostly glyphs that land on or near the screen.
               ox = int'($urandom_range(SCREEN_W + 5)) - 6;
               oy = int'($urandom_range(SCREEN_H + 9)) - 10;
               digit = 4'($urandom_range(9));
            end else begin
               ox = int'($urandom_range(1023)) - 512;
               oy = int'($urandom_range(1023)) - 512;
               digit = 4'($urandom_range(15));
            end
            send_glyph(ox, oy, digit, 16'($urandom_range(65535)));
            drawn++;
            if ($urandom_range(99) < 3) begin
               drain_writes();
            end
         end
         drain_writes();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/sdgr_pkg.sv
rtl/sdgr_glyph_rom.sv
rtl/scaled_digit_glyph_renderer.sv
tb/glyph_write_checker.sv
tb/tb.sv
